// ----- rtl/slpa_pkg.sv -----
// shared types, constants and helpers of the split level page allocator
`timescale 1ns / 1ps
`default_nettype none
package slpa_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int LEVELS_DEF      = 5;
  localparam int FANOUT_DEF      = 512;

  localparam int FRAME_W = 40;
  localparam int LEVEL_W = 3;
  localparam int STAT_W  = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOPAGE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [LEVEL_W-1:0] level;
    logic [FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic [STAT_W-1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LOAD,
    S_SPLIT
  } state_t;

  typedef enum logic [1:0] {
    FIN_FREE,
    FIN_NOPAGE,
    FIN_ALLOC
  } fin_t;

  typedef struct packed {
    logic capture;
    logic push_free;
    logic scan_inc;
    logic pop;
    logic load_base;
    logic split_push;
    logic finish;
    fin_t fin;
  } ctl_t;

  typedef struct packed {
    logic is_free;
    logic lvl_bad;
    logic cur_empty;
    logic src_top;
    logic src_eq_lev;
  } stat_t;

  // frames spanned by one page of a level, wrapping at the frame width
  function automatic logic [FRAME_W-1:0] level_step(input int fanout, input int lev);
    logic [2*FRAME_W-1:0] prod;
    logic [FRAME_W-1:0]   s;
    s = FRAME_W'(1);
    for (int k = 0; k < lev; k++) begin
      prod = s * FRAME_W'(fanout);
      s    = prod[FRAME_W-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/slpa_ctrl.sv -----
// controller state machine of the split level page allocator
`timescale 1ns / 1ps
`default_nettype none
module slpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire slpa_pkg::stat_t st,
  output slpa_pkg::ctl_t      ctl,
  output logic                busy
);

  slpa_pkg::state_t state;
  slpa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.fin    = slpa_pkg::FIN_FREE;
    busy       = 1'b1;
    unique case (state)
      slpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = slpa_pkg::S_DECODE;
        end
      end
      slpa_pkg::S_DECODE: begin
        priority if (st.is_free) begin
          ctl.push_free = 1'b1;
          ctl.finish    = 1'b1;
          ctl.fin       = slpa_pkg::FIN_FREE;
          state_next    = slpa_pkg::S_IDLE;
        end else if (st.lvl_bad) begin
          ctl.finish = 1'b1;
          ctl.fin    = slpa_pkg::FIN_NOPAGE;
          state_next = slpa_pkg::S_IDLE;
        end else begin
          state_next = slpa_pkg::S_SCAN;
        end
      end
      slpa_pkg::S_SCAN: begin
        priority if (!st.cur_empty) begin
          ctl.pop    = 1'b1;
          state_next = slpa_pkg::S_LOAD;
        end else if (st.src_top) begin
          ctl.finish = 1'b1;
          ctl.fin    = slpa_pkg::FIN_NOPAGE;
          state_next = slpa_pkg::S_IDLE;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      slpa_pkg::S_LOAD: begin
        ctl.load_base = 1'b1;
        state_next    = slpa_pkg::S_SPLIT;
      end
      slpa_pkg::S_SPLIT: begin
        if (st.src_eq_lev) begin
          ctl.finish = 1'b1;
          ctl.fin    = slpa_pkg::FIN_ALLOC;
          state_next = slpa_pkg::S_IDLE;
        end else begin
          ctl.split_push = 1'b1;
        end
      end
      default: begin
        state_next = slpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/slpa_dpath.sv -----
// datapath of the split level page allocator: free stacks, counts and split walk
`timescale 1ns / 1ps
`default_nettype none
module slpa_dpath #(
  parameter int STACK_DEPTH = slpa_pkg::STACK_DEPTH_DEF,
  parameter int LEVELS      = slpa_pkg::LEVELS_DEF,
  parameter int FANOUT      = slpa_pkg::FANOUT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire slpa_pkg::req_t req,
  input  wire slpa_pkg::ctl_t ctl,
  output slpa_pkg::stat_t     st,
  output logic                done,
  output slpa_pkg::rsp_t      result
);

  localparam int LW    = $clog2(LEVELS);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int FW    = $clog2(FANOUT);
  localparam int DEPTH = LEVELS * STACK_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int FRW   = slpa_pkg::FRAME_W;

  logic [FRW-1:0] mem [DEPTH];
  logic [FRW-1:0] rd_data;

  logic                         req_cmd;
  logic [slpa_pkg::LEVEL_W-1:0] req_level;
  logic [FRW-1:0]               req_frame;
  logic [LW-1:0]                src;
  logic [FW-1:0]                idx;
  logic [FRW-1:0]               base;
  logic                         dropped;
  logic [CW-1:0]                cnt [LEVELS];
  logic [FRW-1:0]               step_tab [LEVELS];

  logic [LW-1:0]  sub;
  logic [LW-1:0]  tgt;
  logic [CW-1:0]  cnt_tgt;
  logic           full_tgt;
  logic           lvl_bad;
  logic           mem_we;
  logic [FRW-1:0] mem_wdata;
  logic [LW-1:0]  addr_lvl;
  logic [CW-1:0]  addr_idx;
  logic [AW-1:0]  addr;

  for (genvar g = 0; g < LEVELS; g++) begin : g_step
    assign step_tab[g] = slpa_pkg::level_step(FANOUT, g);
  end

  assign lvl_bad   = req_level >= slpa_pkg::LEVEL_W'(LEVELS);
  assign sub       = src - LW'(1);
  assign tgt       = ctl.push_free ? req_level[LW-1:0] : sub;
  assign cnt_tgt   = cnt[tgt];
  assign full_tgt  = cnt_tgt == CW'(STACK_DEPTH);
  assign mem_we    = (ctl.push_free && !lvl_bad && !full_tgt) || (ctl.split_push && !full_tgt);
  assign mem_wdata = ctl.push_free ? req_frame : base;
  assign addr_lvl  = ctl.pop ? src : tgt;
  assign addr_idx  = ctl.pop ? cnt[src] - CW'(1) : cnt_tgt;
  assign addr      = AW'(addr_lvl) * AW'(STACK_DEPTH) + AW'(addr_idx);

  assign st.is_free    = req_cmd == slpa_pkg::CMD_FREE;
  assign st.lvl_bad    = lvl_bad;
  assign st.cur_empty  = cnt[src] == '0;
  assign st.src_top    = src == LW'(LEVELS - 1);
  assign st.src_eq_lev = slpa_pkg::LEVEL_W'(src) == req_level;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    if (ctl.pop) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEVELS; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (mem_we) begin
        cnt[tgt] <= cnt_tgt + CW'(1);
      end else if (ctl.pop) begin
        cnt[src] <= cnt[src] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd   <= req.cmd;
      req_level <= req.level;
      req_frame <= req.frame;
      src       <= req.level[LW-1:0];
      idx       <= '0;
      dropped   <= 1'b0;
    end
    if (ctl.scan_inc) begin
      src <= src + LW'(1);
    end
    if (ctl.load_base) begin
      base <= rd_data;
    end
    if (ctl.split_push) begin
      base <= base + step_tab[sub];
      if (full_tgt) begin
        dropped <= 1'b1;
      end
      if (idx == FW'(FANOUT - 2)) begin
        idx <= '0;
        src <= sub;
      end else begin
        idx <= idx + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      unique case (ctl.fin)
        slpa_pkg::FIN_FREE: begin
          result.frame_out <= '0;
          result.status    <= (lvl_bad || full_tgt) ? slpa_pkg::ST_DROPPED : slpa_pkg::ST_OK;
        end
        slpa_pkg::FIN_NOPAGE: begin
          result.frame_out <= '0;
          result.status    <= slpa_pkg::ST_NOPAGE;
        end
        slpa_pkg::FIN_ALLOC: begin
          result.frame_out <= base;
          result.status    <= dropped ? slpa_pkg::ST_DROPPED : slpa_pkg::ST_OK;
        end
        default: begin
          result.frame_out <= '0;
          result.status    <= slpa_pkg::ST_NOPAGE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/split_level_page_allocator.sv -----
// top level of the split level page allocator
`timescale 1ns / 1ps
`default_nettype none
// Page allocator with LEVELS page sizes, each level a LIFO stack of frame numbers held in
// one single-port memory of LEVELS*STACK_DEPTH entries. A request is taken when start is
// high and busy is low; busy then stays high until the result, which appears on result for
// exactly one cycle with done high and cannot be held off by the receiver. A free, or a
// request with an out-of-range level, is answered from the decode state. An allocate
// first scans upward from its level, one level per cycle, pops one frame (a registered
// memory read, then a load state), then splits down level by level, pushing FANOUT-1
// frames per level at one push per cycle through the memory write port. No clearing pass
// is needed after reset: only the stack counts are cleared.
module split_level_page_allocator #(
  parameter int STACK_DEPTH = slpa_pkg::STACK_DEPTH_DEF,
  parameter int LEVELS      = slpa_pkg::LEVELS_DEF,
  parameter int FANOUT      = slpa_pkg::FANOUT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire slpa_pkg::req_t req,
  output logic                done,
  output slpa_pkg::rsp_t      result
);

  slpa_pkg::ctl_t  ctl;
  slpa_pkg::stat_t st;

  slpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  slpa_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .LEVELS      (LEVELS),
    .FANOUT      (FANOUT)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .ctl    (ctl),
    .st     (st),
    .done   (done),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request taken but block not busy");
  a_nopage_zero: assert property (@(posedge clk) disable iff (rst)
      (done && result.status == slpa_pkg::ST_NOPAGE) |-> result.frame_out == '0)
    else $error("no-page result carries a frame");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a request in flight");
`endif

endmodule
`default_nettype wire
